// ----- src/mad_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mad_pkg
// Shared types, codes and saturation helpers of the advection-diffusion step.
// ----------------------------------------------------------------------------
package mad_pkg;

    localparam int MAX_POINTS_DEF = 4096;
    localparam int IDX_W          = 13;
    localparam int VAL_W          = 32;
    localparam int PHASE_W        = 17;
    localparam logic [PHASE_W-1:0] PHASE_ONE = 17'd65536;

    localparam logic [1:0] REG_D1   = 2'd0;
    localparam logic [1:0] REG_D2   = 2'd1;
    localparam logic [1:0] REG_DT   = 2'd2;
    localparam logic [1:0] REG_STEP = 2'd3;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_COEF  = 2'd1,
        CMD_BOUND = 2'd2,
        CMD_TERM  = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_IDLE, OP_EXEC, OP_DIFF,
        OP_WX, OP_WY, OP_WZ, OP_WL, OP_ACCL,
        OP_K1, OP_K2, OP_VX, OP_VY, OP_VZ, OP_KL,
        OP_RATE, OP_UPD, OP_FIN
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic stencil;
        logic last;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic [30:0] d1;
        logic [30:0] d2;
        logic [30:0] dt;
        logic [31:0] step;
    } cfg_t;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return s;
    endfunction

    function automatic logic [VAL_W-1:0] sat_val(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF)
        begin
            return 32'h7FFF_FFFF;
        end
        else if (v < 64'shFFFF_FFFF_8000_0000)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

// ----- src/mad_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mad_ctrl
// Sequencer: clearing pass, item accept, stencil term and result steps.
// ----------------------------------------------------------------------------
module mad_ctrl
    import mad_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_EXEC, S_DIFF, S_WX, S_WY, S_WZ, S_WL, S_ACCL,
        S_K1, S_K2, S_VX, S_VY, S_VZ, S_KL, S_RATE, S_UPD, S_FIN
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLR;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.op = OP_IDLE;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.op     = OP_EXEC;
                state_next = stat.stencil ? S_DIFF : S_IDLE;
            end
            S_DIFF: begin cmd.op = OP_DIFF; state_next = S_WX;  end
            S_WX:   begin cmd.op = OP_WX;   state_next = S_WY;  end
            S_WY:   begin cmd.op = OP_WY;   state_next = S_WZ;  end
            S_WZ:   begin cmd.op = OP_WZ;   state_next = S_WL;  end
            S_WL:   begin cmd.op = OP_WL;   state_next = S_ACCL; end
            S_ACCL:
            begin
                cmd.op     = OP_ACCL;
                state_next = stat.last ? S_K1 : S_IDLE;
            end
            S_K1:   begin cmd.op = OP_K1;   state_next = S_K2;   end
            S_K2:   begin cmd.op = OP_K2;   state_next = S_VX;   end
            S_VX:   begin cmd.op = OP_VX;   state_next = S_VY;   end
            S_VY:   begin cmd.op = OP_VY;   state_next = S_VZ;   end
            S_VZ:   begin cmd.op = OP_VZ;   state_next = S_KL;   end
            S_KL:   begin cmd.op = OP_KL;   state_next = S_RATE; end
            S_RATE: begin cmd.op = OP_RATE; state_next = S_UPD;  end
            S_UPD:  begin cmd.op = OP_UPD;  state_next = S_FIN;  end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_FIN;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule
`default_nettype wire

// ----- src/mad_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mad_dp
// Datapath: per-point stores, shared multiplier, accumulators, output beat.
// ----------------------------------------------------------------------------
module mad_dp
    import mad_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire dp_cmd_t      cmd,
    output dp_stat_t          stat,
    input  wire cfg_t         cfg,
    input  wire logic         in_valid,
    input  wire logic [1:0]   in_kind,
    input  wire logic         in_last,
    input  wire logic [175:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [79:0]       out_data
);

    localparam int DEPTH = MAX_POINTS + 1;
    localparam int AW    = $clog2(DEPTH);

    logic signed [VAL_W-1:0] pv_mem [DEPTH];
    logic signed [VAL_W-1:0] pr_mem [DEPTH];
    logic signed [VAL_W-1:0] vx_mem [DEPTH];
    logic signed [VAL_W-1:0] vy_mem [DEPTH];
    logic signed [VAL_W-1:0] vz_mem [DEPTH];
    logic signed [VAL_W-1:0] q_mem  [DEPTH];
    logic [PHASE_W-1:0]      ph_mem [DEPTH];
    logic signed [VAL_W-1:0] bv_mem [DEPTH];
    logic                    bf_mem [DEPTH];

    cmd_t                    kind_reg;
    logic                    last_reg;
    logic [IDX_W-1:0]        im_reg, inb_reg;
    logic signed [VAL_W-1:0] wa_reg, wb_reg, wc_reg, wd_reg;
    logic [PHASE_W-1:0]      phin_reg;

    logic signed [VAL_W-1:0] tm_q, tn_q, pr_q, vx_q, vy_q, vz_q, q_q, bv_q;
    logic [PHASE_W-1:0]      ph_q;
    logic                    bf_q;

    logic [AW-1:0]           clr_reg;
    logic signed [32:0]      diff_reg;
    logic signed [67:0]      prod_reg;
    logic signed [63:0]      accx_reg, accy_reg, accz_reg, accl_reg;
    logic [47:0]             t_reg;
    logic [31:0]             k_reg;
    logic signed [55:0]      adv_reg;
    logic signed [VAL_W-1:0] rate_reg;
    logic                    ov_reg;
    logic [79:0]             od_reg;

    logic                    mok, nok, euler;
    logic [AW-1:0]           m_addr, n_addr;
    logic signed [VAL_W-1:0] tm_m, pr_m, vx_m, vy_m, vz_m, q_m;
    logic signed [VAL_W-1:0] gx, gy, gz, lap;
    logic [PHASE_W-1:0]      ph_c;
    logic signed [32:0]      mul_a;
    logic signed [34:0]      mul_b;
    logic                    mul_en;
    logic signed [63:0]      p64;
    logic signed [55:0]      p56, upd56, nv56, rate56;
    logic signed [34:0]      r3, ab;
    logic [48:0]             ksum;
    logic signed [VAL_W-1:0] nv;

    assign mok    = (im_reg != '0) && (32'(im_reg) <= MAX_POINTS);
    assign nok    = (inb_reg != '0) && (32'(inb_reg) <= MAX_POINTS);
    assign m_addr = AW'(im_reg);
    assign n_addr = AW'(inb_reg);
    assign euler  = (cfg.step < 32'd2);

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_IDLE && in_valid)
        begin
            kind_reg <= cmd_t'(in_kind);
            last_reg <= in_last;
            im_reg   <= in_data[12:0];
            inb_reg  <= in_data[25:13];
            wa_reg   <= in_data[57:26];
            wb_reg   <= in_data[89:58];
            wc_reg   <= in_data[121:90];
            wd_reg   <= in_data[153:122];
            phin_reg <= in_data[170:154];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EXEC && mok && kind_reg == CMD_LOAD)
        begin
            pv_mem[m_addr] <= wa_reg;
            pr_mem[m_addr] <= wb_reg;
        end
        if (cmd.op == OP_EXEC)
        begin
            tm_q <= pv_mem[m_addr];
            tn_q <= pv_mem[n_addr];
            pr_q <= pr_mem[m_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EXEC && mok && kind_reg == CMD_COEF)
        begin
            vx_mem[m_addr] <= wa_reg;
            vy_mem[m_addr] <= wb_reg;
            vz_mem[m_addr] <= wc_reg;
            q_mem[m_addr]  <= wd_reg;
            ph_mem[m_addr] <= phin_reg;
        end
        if (cmd.op == OP_EXEC)
        begin
            vx_q <= vx_mem[m_addr];
            vy_q <= vy_mem[m_addr];
            vz_q <= vz_mem[m_addr];
            q_q  <= q_mem[m_addr];
            ph_q <= ph_mem[m_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EXEC && mok && kind_reg == CMD_BOUND)
        begin
            bv_mem[m_addr] <= wa_reg;
        end
        if (cmd.op == OP_EXEC)
        begin
            bv_q <= bv_mem[m_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CLR)
        begin
            bf_mem[clr_reg] <= 1'b0;
        end
        else if (cmd.op == OP_EXEC && mok && kind_reg == CMD_BOUND)
        begin
            bf_mem[m_addr] <= 1'b1;
        end
        if (cmd.op == OP_EXEC)
        begin
            bf_q <= bf_mem[m_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.op == OP_CLR && clr_reg != AW'(DEPTH - 1))
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // out-of-range points read as zero
    assign tm_m = mok ? tm_q : '0;
    assign pr_m = mok ? pr_q : '0;
    assign vx_m = mok ? vx_q : '0;
    assign vy_m = mok ? vy_q : '0;
    assign vz_m = mok ? vz_q : '0;
    assign q_m  = mok ? q_q  : '0;
    assign ph_c = !mok ? '0 : (ph_q > PHASE_ONE) ? PHASE_ONE : ph_q;

    assign gx  = sat_val(accx_reg);
    assign gy  = sat_val(accy_reg);
    assign gz  = sat_val(accz_reg);
    assign lap = sat_val(accl_reg);

    assign r3 = 35'(rate_reg);
    assign ab = (r3 <<< 1) + r3 - 35'(pr_m);

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (cmd.op)
            OP_WX:   begin mul_a = 33'(wa_reg); mul_b = 35'(diff_reg); end
            OP_WY:   begin mul_a = 33'(wb_reg); mul_b = 35'(diff_reg); end
            OP_WZ:   begin mul_a = 33'(wc_reg); mul_b = 35'(diff_reg); end
            OP_WL:   begin mul_a = 33'(wd_reg); mul_b = 35'(diff_reg); end
            OP_K1:
            begin
                mul_a = $signed({16'd0, ph_c});
                mul_b = $signed({4'd0, cfg.d1});
            end
            OP_K2:
            begin
                mul_a = $signed({16'd0, PHASE_ONE - ph_c});
                mul_b = $signed({4'd0, cfg.d2});
            end
            OP_VX:   begin mul_a = 33'(vx_m); mul_b = 35'(gx); end
            OP_VY:   begin mul_a = 33'(vy_m); mul_b = 35'(gy); end
            OP_VZ:   begin mul_a = 33'(vz_m); mul_b = 35'(gz); end
            OP_KL:   begin mul_a = $signed({1'b0, k_reg}); mul_b = 35'(lap); end
            OP_UPD:
            begin
                mul_a = $signed({2'd0, cfg.dt});
                mul_b = euler ? 35'(rate_reg) : ab;
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign p64    = 64'($signed(prod_reg[67:16]));
    assign p56    = 56'($signed(prod_reg[67:16]));
    assign ksum   = {1'b0, t_reg} + {1'b0, prod_reg[47:0]};
    assign rate56 = p56 - adv_reg + 56'(q_m);
    assign upd56  = euler ? p56 : 56'($signed(prod_reg[67:17]));
    assign nv56   = upd56 + 56'(tm_m);
    assign nv     = (mok && bf_q) ? bv_q : sat_val(64'(nv56));

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        unique case (cmd.op)
            OP_DIFF: diff_reg <= 33'(nok ? tn_q : 32'sd0) - 33'(tm_m);
            OP_K2:   t_reg    <= prod_reg[47:0];
            OP_VX:   k_reg    <= ksum[47:16];
            OP_VY:   adv_reg  <= p56;
            OP_VZ:   adv_reg  <= adv_reg + p56;
            OP_KL:   adv_reg  <= adv_reg + p56;
            OP_RATE: rate_reg <= sat_val(64'(rate56));
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accx_reg <= '0;
            accy_reg <= '0;
            accz_reg <= '0;
            accl_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_WY:   accx_reg <= sat_add64(accx_reg, p64);
                OP_WZ:   accy_reg <= sat_add64(accy_reg, p64);
                OP_WL:   accz_reg <= sat_add64(accz_reg, p64);
                OP_ACCL: accl_reg <= sat_add64(accl_reg, p64);
                OP_FIN:
                begin
                    accx_reg <= '0;
                    accy_reg <= '0;
                    accz_reg <= '0;
                    accl_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.op == OP_FIN)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FIN)
        begin
            od_reg <= {3'd0, rate_reg, nv, im_reg};
        end
    end

    assign out_valid     = ov_reg;
    assign out_data      = od_reg;
    assign stat.clr_done = (clr_reg == AW'(DEPTH - 1));
    assign stat.stencil  = (kind_reg == CMD_TERM);
    assign stat.last     = last_reg;
    assign stat.out_free = !ov_reg || out_ready;

endmodule
`default_nettype wire

// ----- src/meshless_advect_diffuse_ab2.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// meshless_advect_diffuse_ab2
// One explicit advection-diffusion time step on a point cloud, Q16.16.
// ----------------------------------------------------------------------------
// After reset the boundary flag store is swept clear; no beat is accepted
// during the sweep. Load, coefficient and boundary beats are stored; a stencil
// term adds four weighted neighbour differences; a closing term also forms the
// diffusivity, advection, rate and update and yields one output beat. All
// products go through one shared 33x35 multiplier, one per cycle. The output
// beat is registered, so a new input beat is accepted while a result waits.
module meshless_advect_diffuse_ab2
    import mad_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // index_main, index_nbr, word_a, word_b, word_c, word_d, phase_in, pad
    input  wire logic [175:0] s_axis_tdata,
    // cmd
    input  wire logic [1:0]   s_axis_tuser,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // point_out, new_value, rate_out, pad
    output logic [79:0]       m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t     cfg_reg;
    dp_cmd_t  dcmd;
    dp_stat_t dstat;
    logic     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.d1   <= 31'd65536;
            cfg_reg.d2   <= 31'd65536;
            cfg_reg.dt   <= 31'd655;
            cfg_reg.step <= 32'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_D1:   cfg_reg.d1   <= pwdata[30:0];
                REG_D2:   cfg_reg.d2   <= pwdata[30:0];
                REG_DT:   cfg_reg.dt   <= pwdata[30:0];
                REG_STEP: cfg_reg.step <= pwdata;
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_D1:   prdata = {1'b0, cfg_reg.d1};
            REG_D2:   prdata = {1'b0, cfg_reg.d2};
            REG_DT:   prdata = {1'b0, cfg_reg.dt};
            REG_STEP: prdata = cfg_reg.step;
            default:  prdata = '0;
        endcase
    end

    mad_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (dstat),
        .cmd      (dcmd)
    );

    mad_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dcmd),
        .stat      (dstat),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_kind   (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_fin_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
        dcmd.op == OP_FIN |=> m_axis_tvalid)
        else $error("result not presented after finish");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dcmd.op == OP_FIN |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");
    a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        dcmd.op == OP_CLR |-> !s_axis_tready)
        else $error("beat accepted during clearing pass");
`endif

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the advection-diffusion point update against a built-in predictor.
// Directed beats cover field extremes, boundary points, out-of-range indices,
// a main index changed inside a stencil and clamped phase fractions. Random
// stencils over loaded points follow, with a few register settings, random
// idling on both streams and none in the last phase.
// ----------------------------------------------------------------------------
module testbench;
    import mad_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [12:0] im;
        logic [12:0] inb;
        logic [31:0] wa, wb, wc, wd;
        logic [16:0] ph;
        logic        last;
    } beat_t;

    typedef struct {
        logic [12:0] pt;
        logic [31:0] nv;
        logic [31:0] rate;
    } point_result_t;

    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = 64'sh8000_0000_0000_0000;
    localparam int     NPTS    = 4096;
    localparam int     LIMIT   = 400000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [175:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    meshless_advect_diffuse_ab2 i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // predictor state
    logic signed [31:0] pt_value [0:NPTS];
    logic signed [31:0] pt_prev  [0:NPTS];
    logic signed [31:0] pt_vx    [0:NPTS];
    logic signed [31:0] pt_vy    [0:NPTS];
    logic signed [31:0] pt_vz    [0:NPTS];
    logic signed [31:0] pt_src   [0:NPTS];
    logic [16:0]        pt_phase [0:NPTS];
    logic signed [31:0] pt_bval  [0:NPTS];
    logic               pt_bflag [0:NPTS];
    longint             acc_gx, acc_gy, acc_gz, acc_lap;
    logic [30:0]        diff_1, diff_2, dt_cfg;
    logic [31:0]        step_cfg;

    // generation-side bookkeeping so no unwritten entry is ever read
    logic               gen_val  [0:8191];
    logic               gen_coef [0:8191];
    int                 usable_pts[$];

    beat_t              pending_beats[$];
    point_result_t      expected_points[$];
    bit                 calm = 1'b0;
    int                 errors = 0;
    int                 n_beats = 0;
    int                 n_points = 0;
    int                 cycles = 0;

    function automatic longint add_sat(longint a, longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            return a[63] ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sh7FFF_FFFF)
        begin
            return 64'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000)
        begin
            return -64'sh8000_0000;
        end
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b, int sh);
        logic signed [127:0] pa, pb, p;
        pa = a;
        pb = b;
        p = (pa * pb) >>> sh;
        if (p > 128'sh7FFF_FFFF_FFFF_FFFF)
        begin
            return S64_MAX;
        end
        if (p < -128'sh8000_0000_0000_0000)
        begin
            return S64_MIN;
        end
        return p[63:0];
    endfunction

    function automatic bit in_range(logic [12:0] i);
        return i >= 1 && i <= NPTS;
    endfunction

    task automatic apply_beat(beat_t b);
        bit            mok;
        int            m;
        longint        tm, tn, dif, gx, gy, gz, lap, k, adv, rate, upd, nv, prv;
        longint unsigned ph, kfull;
        point_result_t r;
        mok = in_range(b.im);
        m = mok ? int'(b.im) : 0;
        case (b.cmd)
            CMD_LOAD:
            begin
                if (mok)
                begin
                    pt_value[m] = b.wa;
                    pt_prev[m] = b.wb;
                end
            end
            CMD_COEF:
            begin
                if (mok)
                begin
                    pt_vx[m] = b.wa;
                    pt_vy[m] = b.wb;
                    pt_vz[m] = b.wc;
                    pt_src[m] = b.wd;
                    pt_phase[m] = b.ph;
                end
            end
            CMD_BOUND:
            begin
                if (mok)
                begin
                    pt_bval[m] = b.wa;
                    pt_bflag[m] = 1'b1;
                end
            end
            default:
            begin
                tm = mok ? longint'(pt_value[m]) : 0;
                tn = in_range(b.inb) ? longint'(pt_value[b.inb]) : 0;
                dif = tn - tm;
                acc_gx = add_sat(acc_gx, qmul(longint'($signed(b.wa)), dif, 16));
                acc_gy = add_sat(acc_gy, qmul(longint'($signed(b.wb)), dif, 16));
                acc_gz = add_sat(acc_gz, qmul(longint'($signed(b.wc)), dif, 16));
                acc_lap = add_sat(acc_lap, qmul(longint'($signed(b.wd)), dif, 16));
                if (b.last)
                begin
                    gx = clip32(acc_gx);
                    gy = clip32(acc_gy);
                    gz = clip32(acc_gz);
                    lap = clip32(acc_lap);
                    acc_gx = 0;
                    acc_gy = 0;
                    acc_gz = 0;
                    acc_lap = 0;
                    ph = mok ? pt_phase[m] : 0;
                    if (ph > 65536)
                    begin
                        ph = 65536;
                    end
                    kfull = ph * diff_1 + (65536 - ph) * diff_2;
                    k = longint'(kfull >> 16);
                    adv = add_sat(add_sat(qmul(mok ? pt_vx[m] : 0, gx, 16),
                                          qmul(mok ? pt_vy[m] : 0, gy, 16)),
                                  qmul(mok ? pt_vz[m] : 0, gz, 16));
                    rate = qmul(k, lap, 16);
                    rate = add_sat(rate, adv == S64_MIN ? S64_MAX : -adv);
                    rate = clip32(add_sat(rate, mok ? pt_src[m] : 0));
                    if (step_cfg < 2)
                    begin
                        upd = qmul(longint'(dt_cfg), rate, 16);
                    end
                    else
                    begin
                        prv = mok ? longint'(pt_prev[m]) : 0;
                        upd = qmul(longint'(dt_cfg), 3 * rate - prv, 17);
                    end
                    nv = clip32(add_sat(tm, upd));
                    if (mok && pt_bflag[m])
                    begin
                        nv = pt_bval[m];
                    end
                    r.pt = b.im;
                    r.nv = nv[31:0];
                    r.rate = rate[31:0];
                    expected_points.push_back(r);
                end
            end
        endcase
    endtask

    // stimulus helpers
    task automatic add_beat(cmd_t c, int im, int inb, logic [31:0] a, logic [31:0] bw,
                            logic [31:0] cw, logic [31:0] dw, logic [16:0] ph, bit last);
        beat_t b;
        b.cmd = c;
        b.im = im[12:0];
        b.inb = inb[12:0];
        b.wa = a;
        b.wb = bw;
        b.wc = cw;
        b.wd = dw;
        b.ph = ph;
        b.last = last;
        if (in_range(b.im) && (c == CMD_LOAD || c == CMD_COEF))
        begin
            if (!(gen_val[b.im] && gen_coef[b.im]))
            begin
                if (c == CMD_LOAD)
                begin
                    gen_val[b.im] = 1'b1;
                end
                else
                begin
                    gen_coef[b.im] = 1'b1;
                end
                if (gen_val[b.im] && gen_coef[b.im])
                begin
                    usable_pts.push_back(b.im);
                end
            end
        end
        pending_beats.push_back(b);
    endtask

    function automatic logic [31:0] rnd_word();
        logic [31:0] w;
        case ($urandom_range(0, 4))
            0: w = $urandom;
            1: w = $urandom_range(0, 1 << 20) - (1 << 19);
            2: w = $urandom_range(0, 1 << 25) - (1 << 24);
            3: w = $urandom_range(0, 1 << 17) - (1 << 16);
            default:
            begin
                case ($urandom_range(0, 4))
                    0: w = 32'h7FFF_FFFF;
                    1: w = 32'h8000_0000;
                    2: w = 32'h0001_0000;
                    3: w = 32'hFFFF_0000;
                    default: w = 32'h0;
                endcase
            end
        endcase
        return w;
    endfunction

    function automatic logic [16:0] rnd_phase();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(65537, 131071);
        end
        return $urandom_range(0, 65536);
    endfunction

    function automatic int rnd_pool_index();
        if ($urandom_range(0, 4) == 0)
        begin
            return $urandom_range(4088, 4096);
        end
        return $urandom_range(1, 40);
    endfunction

    function automatic int rnd_bad_index();
        return $urandom_range(0, 1) ? 0 : $urandom_range(4097, 8191);
    endfunction

    function automatic int pick_point();
        return usable_pts[$urandom_range(0, usable_pts.size() - 1)];
    endfunction

    task automatic gen_random(int count);
        int done, nterms, main_pt, nbr, c;
        done = 0;
        while (done < count)
        begin
            c = $urandom_range(0, 19);
            if (c < 2)
            begin
                add_beat(CMD_LOAD, rnd_pool_index(), $urandom_range(0, 8191), rnd_word(),
                         rnd_word(), $urandom, $urandom, $urandom, $urandom_range(0, 1));
                done++;
            end
            else if (c < 4)
            begin
                add_beat(CMD_COEF, rnd_pool_index(), $urandom_range(0, 8191), rnd_word(),
                         rnd_word(), rnd_word(), rnd_word(), rnd_phase(),
                         $urandom_range(0, 1));
                done++;
            end
            else if (c == 4)
            begin
                add_beat(CMD_BOUND, $urandom_range(30, 40), 0, rnd_word(), $urandom,
                         $urandom, $urandom, $urandom, $urandom_range(0, 1));
                done++;
            end
            else if (c == 5)
            begin
                add_beat(cmd_t'($urandom_range(0, 2)), rnd_bad_index(), 0, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
            end
            else
            begin
                nterms = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                      : $urandom_range(1, 5);
                main_pt = ($urandom_range(0, 19) == 0) ? rnd_bad_index() : pick_point();
                for (int t = 0; t < nterms; t++)
                begin
                    if ($urandom_range(0, 24) == 0)
                    begin
                        main_pt = pick_point();
                    end
                    nbr = ($urandom_range(0, 7) == 0) ? rnd_bad_index() : pick_point();
                    add_beat(CMD_TERM, main_pt, nbr, rnd_word(), rnd_word(), rnd_word(),
                             rnd_word(), $urandom, t == nterms - 1);
                    done++;
                end
            end
        end
    endtask

    task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (reg_idx)
            REG_D1: diff_1 = value[30:0];
            REG_D2: diff_2 = value[30:0];
            REG_DT: dt_cfg = value[30:0];
            default: step_cfg = value;
        endcase
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || s_axis_tvalid || expected_points.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
    endtask

    task automatic set_config(logic [31:0] d1, logic [31:0] d2, logic [31:0] dt,
                              logic [31:0] st);
        drain();
        apb_write(REG_D1, d1);
        apb_write(REG_D2, d2);
        apb_write(REG_DT, dt);
        apb_write(REG_STEP, st);
    endtask

    // input driver
    int in_gap = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                beat_t b;
                b = pending_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= b.cmd;
                s_axis_tlast <= b.last;
                s_axis_tdata <= {5'b0, b.ph, b.wd, b.wc, b.wb, b.wa, b.inb, b.im};
                if (!calm && $urandom_range(0, 9) == 0)
                begin
                    in_gap = $urandom_range(1, 7);
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output backpressure
    int out_stall = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (out_stall > 0)
        begin
            out_stall--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall = $urandom_range(1, 7);
            end
        end
    end

    // monitor: predict on accepted input beats, check accepted output beats
    always @(posedge clk)
    begin
        beat_t         b;
        point_result_t e;
        if (rst_n)
        begin
            cycles++;
            if (s_axis_tvalid && s_axis_tready)
            begin
                b.cmd = cmd_t'(s_axis_tuser);
                b.last = s_axis_tlast;
                b.im = s_axis_tdata[12:0];
                b.inb = s_axis_tdata[25:13];
                b.wa = s_axis_tdata[57:26];
                b.wb = s_axis_tdata[89:58];
                b.wc = s_axis_tdata[121:90];
                b.wd = s_axis_tdata[153:122];
                b.ph = s_axis_tdata[170:154];
                apply_beat(b);
                n_beats++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_points++;
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    e = expected_points.pop_front();
                    if (m_axis_tdata[12:0] !== e.pt)
                    begin
                        $display("%0t: point_out exp %0d got %0d", $time, e.pt,
                                 m_axis_tdata[12:0]);
                        errors++;
                    end
                    if (m_axis_tdata[44:13] !== e.nv)
                    begin
                        $display("%0t: new_value exp %h got %h", $time, e.nv,
                                 m_axis_tdata[44:13]);
                        errors++;
                    end
                    if (m_axis_tdata[76:45] !== e.rate)
                    begin
                        $display("%0t: rate_out exp %h got %h", $time, e.rate,
                                 m_axis_tdata[76:45]);
                        errors++;
                    end
                end
            end
            if (cycles > LIMIT)
            begin
                $display("%0t: timeout", $time);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i <= NPTS; i++)
        begin
            pt_bflag[i] = 1'b0;
        end
        for (int i = 0; i < 8192; i++)
        begin
            gen_val[i] = 1'b0;
            gen_coef[i] = 1'b0;
        end
        acc_gx = 0;
        acc_gy = 0;
        acc_gz = 0;
        acc_lap = 0;
        diff_1 = 31'd65536;
        diff_2 = 31'd65536;
        dt_cfg = 31'd655;
        step_cfg = 32'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        add_beat(CMD_LOAD, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0);
        add_beat(CMD_LOAD, 2, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0);
        add_beat(CMD_LOAD, 3, 0, 32'h0001_0000, 32'h0, 0, 0, 0, 0);
        add_beat(CMD_LOAD, 4096, 8191, 32'hFFFF_8000, 32'h0002_0000, '1, '1, '1, 1);
        add_beat(CMD_COEF, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0,
                 17'd0, 0);
        add_beat(CMD_COEF, 2, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
                 32'h7FFF_FFFF, 17'd65536, 0);
        add_beat(CMD_COEF, 3, 0, 32'h0000_8000, 32'h0, 32'h0, 32'h0001_0000,
                 17'd131071, 0);
        add_beat(CMD_COEF, 4096, 0, 32'h0, 32'h0001_0000, 32'h0, 32'h8000_0000,
                 17'd32768, 0);
        add_beat(CMD_BOUND, 3, 0, 32'h1234_5678, 0, 0, 0, 0, 0);
        add_beat(CMD_LOAD, 0, 0, $urandom, $urandom, 0, 0, 0, 0);
        add_beat(CMD_COEF, 8191, 8191, '1, '1, '1, '1, '1, 1);
        add_beat(CMD_BOUND, 4097, 0, $urandom, 0, 0, 0, 0, 0);
        add_beat(CMD_TERM, 1, 2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 0, 1);
        add_beat(CMD_TERM, 2, 1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 32'h0001_0000, 0, 1);
        add_beat(CMD_TERM, 3, 1, 32'h0001_0000, 32'h0, 32'h0, 32'h0004_0000, 0, 0);
        add_beat(CMD_TERM, 3, 8191, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0002_0000, 0, 1);
        add_beat(CMD_TERM, 4096, 0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 0, 0);
        add_beat(CMD_TERM, 1, 4096, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 0, 0);
        add_beat(CMD_TERM, 2, 3, 32'h0000_1000, 32'h0, 32'h0, 32'h0001_0000, 0, 1);
        add_beat(CMD_TERM, 0, 1, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 0, 1);
        add_beat(CMD_TERM, 8191, 2, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 0, 1);
        gen_random(200);

        set_config(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'd1);
        gen_random(220);
        set_config(32'h0, 32'h7FFF_FFFF, 32'h0, 32'd2);
        gen_random(220);
        set_config($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                   $urandom_range(0, 1 << 16), 32'hFFFF_FFFF);
        gen_random(220);
        set_config($urandom, $urandom, $urandom, $urandom_range(2, 1000));
        calm = 1'b1;
        gen_random(200);

        drain();
        $display("Covered %0d accepted input beats and %0d point results", n_beats,
                 n_points);
        $display("across five register settings including both diffusivity extremes.");
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
